// ===== rtl/c15cfe_pkg.sv =====
// shared types, constants and crc helpers for the crc-15 command frame engine
// used by c15cfe_framer and crc15_command_frame_engine; no dependencies
package c15cfe_pkg;

  localparam logic [15:0] CRC_POLY     = 16'h4599;
  localparam logic [15:0] CRC_SEED     = 16'd16;
  localparam logic [4:0]  MAX_DATA     = 5'd26;
  localparam logic [7:0]  MISMATCH_MAX = 8'd255;
  localparam logic [7:0]  HDR_MARK     = 8'h80;

  typedef enum logic [1:0] {
    REQ_HEADER  = 2'd0,
    REQ_TX_DATA = 2'd1,
    REQ_RX_DATA = 2'd2,
    REQ_RX_CRC  = 2'd3
  } req_t;

  typedef enum logic {
    KIND_TX     = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    req_t        req_type;
    logic [3:0]  device_address;
    logic [10:0] command_code;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] rx_crc;
  } item_t;

  typedef struct packed {
    logic [15:0] crc_rem;
    logic [4:0]  byte_count;
    logic        link_ok;
    logic [7:0]  mismatch_count;
    logic        overflow_flag;
  } state_t;

  // up to four result words per item, slot 0 goes out first
  typedef struct packed {
    logic [2:0]      count;
    kind_t           kind;
    logic [3:0][7:0] bytes;
  } res_t;

  // one byte into the crc-15 remainder
  function automatic logic [15:0] crc_byte(input logic [15:0] rem, input logic [7:0] b);
    logic [15:0] t;
    logic        top;
    t = {1'b0, rem[14:7] ^ b, 7'b0};
    for (int k = 0; k < 8; k++) begin
      top = t[14];
      t   = {t[14:0], 1'b0};
      if (top) begin
        t = t ^ CRC_POLY;
      end
    end
    return {rem[7:0], 8'h00} ^ t;
  endfunction

  // word on the wire is the remainder shifted up one bit
  function automatic logic [15:0] crc_word(input logic [15:0] rem);
    return {rem[14:0], 1'b0};
  endfunction

endpackage

// ===== rtl/crc15_command_frame_engine.sv =====
// top level of the crc-15 command frame engine: input register, framer, result buffer
// depends on c15cfe_pkg and c15cfe_framer
//
//  channel | dir | words                | fields (tuser / tlast / tdata)
//  in_     | in  | one request per word | req_type / last_byte / address,cmd,data,rx_crc
//  out_    | out | one byte or status   | kind / end_of_run / tx_byte,crc_ok,errors,ovf
//
// a request word is taken every cycle while the result buffer drains in time;
// each request passes the input register before its results load the result buffer
// a header gives four result words, a last data byte two or three,
// all other requests give one or no result word, so the output port sets the rate
// reset (rst_n low at a clock edge) seeds the crc and clears counters and flags
// a stall on out_tready holds the buffer and backs up into in_tready
module crc15_command_frame_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // device_address[3:0], command_code[14:4], data_byte[22:15],
                                 // rx_crc[38:23], zero pad[39]
  input  logic [1:0]  in_tuser,  // req_type[1:0]
  input  logic        in_tlast,  // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // tx_byte[7:0], crc_ok[8], error_total[16:9],
                                 // overflow[17], zero pad[23:18]
  output logic        out_tuser, // kind
  output logic        out_tlast  // end_of_run
);

  // input register
  logic               s1_valid_r;
  c15cfe_pkg::item_t  s1_item_r;

  // frame and check state
  c15cfe_pkg::state_t st_r;
  c15cfe_pkg::state_t st_nxt;
  c15cfe_pkg::res_t   res;

  // result buffer, slot 0 is the head word
  logic [2:0]         buf_cnt_r;
  logic [3:0][7:0]    buf_bytes_r;
  c15cfe_pkg::kind_t  buf_kind_r;
  logic               buf_link_r;
  logic [7:0]         buf_err_r;
  logic               buf_ovf_r;

  logic out_fire;
  logic load_ok;
  logic proceed;

  assign out_fire  = out_tvalid && out_tready;
  // buffer free for a new item once it is empty or its last word leaves now
  assign load_ok   = (buf_cnt_r == 3'd0) || (buf_cnt_r == 3'd1 && out_tready);
  assign proceed   = s1_valid_r && load_ok;
  assign in_tready = !s1_valid_r || proceed;

  c15cfe_framer u_framer (
    .item (s1_item_r),
    .cur  (st_r),
    .nxt  (st_nxt),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.req_type       <= c15cfe_pkg::req_t'(in_tuser);
      s1_item_r.device_address <= in_tdata[3:0];
      s1_item_r.command_code   <= in_tdata[14:4];
      s1_item_r.data_byte      <= in_tdata[22:15];
      s1_item_r.last_byte      <= in_tlast;
      s1_item_r.rx_crc         <= in_tdata[38:23];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.crc_rem        <= c15cfe_pkg::CRC_SEED;
      st_r.byte_count     <= 5'd0;
      st_r.link_ok        <= 1'b0;
      st_r.mismatch_count <= 8'd0;
      st_r.overflow_flag  <= 1'b0;
    end else if (proceed) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= 3'd0;
    end else if (proceed) begin
      buf_cnt_r <= res.count;
    end else if (out_fire) begin
      buf_cnt_r <= buf_cnt_r - 3'd1;
    end
  end

  // payload: status fields carry the state after the item
  always_ff @(posedge clk) begin
    if (proceed) begin
      buf_bytes_r <= res.bytes;
      buf_kind_r  <= res.kind;
      buf_link_r  <= st_nxt.link_ok;
      buf_err_r   <= st_nxt.mismatch_count;
      buf_ovf_r   <= st_nxt.overflow_flag;
    end else if (out_fire) begin
      buf_bytes_r <= {8'h00, buf_bytes_r[3:1]};
    end
  end

  assign out_tvalid = buf_cnt_r != 3'd0;
  assign out_tuser  = buf_kind_r;
  assign out_tlast  = buf_cnt_r == 3'd1;
  assign out_tdata  = {6'b000000, buf_ovf_r, buf_err_r, buf_link_r, buf_bytes_r[0]};

  // buffer never holds more than a header's four words
  a_buf_depth: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt_r <= 3'd4)
    else $error("result buffer count out of range");

  // received or sent bytes never run past the frame limit
  a_byte_limit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.byte_count <= c15cfe_pkg::MAX_DATA)
    else $error("byte count beyond frame limit");

  // link ok only ever comes with a cleared mismatch counter
  a_link_err: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.link_ok |-> st_r.mismatch_count == 8'd0)
    else $error("link ok with nonzero mismatch count");

  // a status word is a single-word run with no byte
  a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == c15cfe_pkg::KIND_STATUS) |-> (out_tlast && out_tdata[7:0] == 8'h00))
    else $error("malformed status word");

  // a stalled result word keeps its place in the run
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(buf_cnt_r))
    else $error("result buffer moved under stall");

endmodule

// ===== rtl/c15cfe_framer.sv =====
// next-state and result words for one registered request
// depends on c15cfe_pkg (types, crc helpers)
module c15cfe_framer (
  input  c15cfe_pkg::item_t  item,
  input  c15cfe_pkg::state_t cur,
  output c15cfe_pkg::state_t nxt,
  output c15cfe_pkg::res_t   res
);

  logic        room;
  logic [7:0]  hdr_b0;
  logic [7:0]  hdr_b1;
  logic [15:0] hdr_word;
  logic [15:0] data_rem;
  logic [4:0]  data_cnt;
  logic [15:0] data_word;
  logic [15:0] chk_word;

  assign room     = cur.byte_count < c15cfe_pkg::MAX_DATA;
  assign hdr_b0   = c15cfe_pkg::HDR_MARK | {1'b0, item.device_address, item.command_code[10:8]};
  assign hdr_b1   = item.command_code[7:0];
  assign hdr_word = c15cfe_pkg::crc_word(c15cfe_pkg::crc_byte(
                      c15cfe_pkg::crc_byte(c15cfe_pkg::CRC_SEED, hdr_b0), hdr_b1));

  // data byte folded in only while there is room
  assign data_rem  = room ? c15cfe_pkg::crc_byte(cur.crc_rem, item.data_byte) : cur.crc_rem;
  assign data_cnt  = room ? cur.byte_count + 5'd1 : cur.byte_count;
  assign data_word = c15cfe_pkg::crc_word(data_rem);
  assign chk_word  = c15cfe_pkg::crc_word(cur.crc_rem);

  always_comb begin
    nxt       = cur;
    res.count = 3'd0;
    res.kind  = c15cfe_pkg::KIND_TX;
    res.bytes = '0;
    case (item.req_type)
      c15cfe_pkg::REQ_HEADER: begin
        nxt.crc_rem       = c15cfe_pkg::CRC_SEED;
        nxt.byte_count    = 5'd0;
        nxt.overflow_flag = 1'b0;
        res.count         = 3'd4;
        res.bytes         = {hdr_word[7:0], hdr_word[15:8], hdr_b1, hdr_b0};
      end
      c15cfe_pkg::REQ_TX_DATA: begin
        nxt.crc_rem    = data_rem;
        nxt.byte_count = data_cnt;
        if (!room) begin
          nxt.overflow_flag = 1'b1;
        end
        if (item.last_byte && data_cnt != 5'd0) begin
          nxt.crc_rem    = c15cfe_pkg::CRC_SEED;
          nxt.byte_count = 5'd0;
          if (room) begin
            res.count = 3'd3;
            res.bytes = {8'h00, data_word[7:0], data_word[15:8], item.data_byte};
          end else begin
            res.count = 3'd2;
            res.bytes = {16'h0000, data_word[7:0], data_word[15:8]};
          end
        end else if (room) begin
          res.count = 3'd1;
          res.bytes = {24'h000000, item.data_byte};
        end
      end
      c15cfe_pkg::REQ_RX_DATA: begin
        nxt.crc_rem    = data_rem;
        nxt.byte_count = data_cnt;
        if (!room) begin
          nxt.overflow_flag = 1'b1;
        end
      end
      c15cfe_pkg::REQ_RX_CRC: begin
        if (cur.byte_count != 5'd0) begin
          if (item.rx_crc == chk_word) begin
            nxt.link_ok        = 1'b1;
            nxt.mismatch_count = 8'd0;
          end else begin
            nxt.link_ok = 1'b0;
            if (cur.mismatch_count != c15cfe_pkg::MISMATCH_MAX) begin
              nxt.mismatch_count = cur.mismatch_count + 8'd1;
            end
          end
          nxt.crc_rem    = c15cfe_pkg::CRC_SEED;
          nxt.byte_count = 5'd0;
          res.count      = 3'd1;
          res.kind       = c15cfe_pkg::KIND_STATUS;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ===== verif/tb_crc15_command_frame_engine.sv =====
`timescale 1ns / 1ps
// self-checking bench for crc15_command_frame_engine: queued request words drive the
// in_ stream, a built-in predictor forms the expected out_ words, a monitor checks them
// depends on c15cfe_pkg and the rtl of crc15_command_frame_engine
module tb_crc15_command_frame_engine;

  // no word moving for this many cycles means the block is stuck
  localparam int WATCHDOG_LIMIT = 4000;
  // settle time after the last expected word
  localparam int DRAIN_CYCLES   = 16;
  localparam int REPORT_LIMIT   = 10;

  // one result word as seen on out_
  typedef struct packed {
    c15cfe_pkg::kind_t kind;
    logic [7:0]        tx_byte;
    logic              end_of_run;
    logic              crc_ok;
    logic [7:0]        error_total;
    logic              overflow;
  } result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;  // device_address[3:0], command_code[14:4], data_byte[22:15],
                                 // rx_crc[38:23], zero pad[39]
  logic [1:0]  in_tuser   = '0;  // req_type[1:0]
  logic        in_tlast   = 1'b0; // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // tx_byte[7:0], crc_ok[8], error_total[16:9],
                                 // overflow[17], zero pad[23:18]
  logic        out_tuser;        // kind
  logic        out_tlast;        // end_of_run

  always #2 clk = ~clk;

  crc15_command_frame_engine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // request words waiting for the driver, and the word currently offered
  c15cfe_pkg::item_t pending_reqs[$];
  c15cfe_pkg::item_t req_on_bus;
  // result words the block still owes, oldest first
  result_t owed_results[$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int mismatch_total     = 0;
  int quiet_cycles       = 0;
  int queued_items       = 0;

  // predictor copy of the block state
  logic [15:0] frame_crc   = c15cfe_pkg::CRC_SEED;
  logic [4:0]  frame_bytes = '0;
  logic        link_good   = 1'b0;
  logic [7:0]  bad_checks  = '0;
  logic        dropped     = 1'b0;

  // stimulus-side running crc, used to build matching and broken check words
  logic [15:0] gen_crc   = c15cfe_pkg::CRC_SEED;
  logic [4:0]  gen_bytes = '0;

  // one byte into the crc-15 accumulator: table value of the top byte, then shift in
  function automatic logic [15:0] crc15_feed(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] mix;
    mix = {1'b0, acc[14:7] ^ b, 7'd0};
    for (int i = 0; i < 8; i++) begin
      mix = mix[14] ? ((mix << 1) ^ c15cfe_pkg::CRC_POLY) : (mix << 1);
    end
    return (acc << 8) ^ mix;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("kind=%0d byte=%02h eor=%0b ok=%0b errs=%0d ovf=%0b",
                     r.kind, r.tx_byte, r.end_of_run, r.crc_ok, r.error_total, r.overflow);
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_total++;
    if (mismatch_total <= REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  // status fields always reflect the state after the whole request
  function automatic void owe_result(input c15cfe_pkg::kind_t k, input logic [7:0] b,
                                     input logic eor);
    result_t r;
    r.kind        = k;
    r.tx_byte     = b;
    r.end_of_run  = eor;
    r.crc_ok      = link_good;
    r.error_total = bad_checks;
    r.overflow    = dropped;
    owed_results.push_back(r);
  endfunction

  // work out the result words of one accepted request word
  task automatic predict_frame_words(input c15cfe_pkg::item_t it);
    logic [7:0]      hdr_hi;
    logic [7:0]      hdr_lo;
    logic [15:0]     word;
    logic [2:0][7:0] tx_bytes;
    int              n;
    n = 0;
    case (it.req_type)
      c15cfe_pkg::REQ_HEADER: begin
        hdr_hi      = c15cfe_pkg::HDR_MARK | {1'b0, it.device_address, it.command_code[10:8]};
        hdr_lo      = it.command_code[7:0];
        word        = crc15_feed(crc15_feed(c15cfe_pkg::CRC_SEED, hdr_hi), hdr_lo) << 1;
        frame_crc   = c15cfe_pkg::CRC_SEED;
        frame_bytes = '0;
        dropped     = 1'b0;
        owe_result(c15cfe_pkg::KIND_TX, hdr_hi, 1'b0);
        owe_result(c15cfe_pkg::KIND_TX, hdr_lo, 1'b0);
        owe_result(c15cfe_pkg::KIND_TX, word[15:8], 1'b0);
        owe_result(c15cfe_pkg::KIND_TX, word[7:0], 1'b1);
      end
      c15cfe_pkg::REQ_TX_DATA: begin
        if (frame_bytes < c15cfe_pkg::MAX_DATA) begin
          frame_crc   = crc15_feed(frame_crc, it.data_byte);
          frame_bytes = frame_bytes + 5'd1;
          tx_bytes[n] = it.data_byte;
          n++;
        end else begin
          dropped = 1'b1;
        end
        // last mark closes the frame with the crc of the bytes that got through
        if (it.last_byte && frame_bytes != 0) begin
          word          = frame_crc << 1;
          frame_crc     = c15cfe_pkg::CRC_SEED;
          frame_bytes   = '0;
          tx_bytes[n]   = word[15:8];
          tx_bytes[n+1] = word[7:0];
          n += 2;
        end
        for (int k = 0; k < n; k++) begin
          owe_result(c15cfe_pkg::KIND_TX, tx_bytes[k], k == n - 1);
        end
      end
      c15cfe_pkg::REQ_RX_DATA: begin
        if (frame_bytes < c15cfe_pkg::MAX_DATA) begin
          frame_crc   = crc15_feed(frame_crc, it.data_byte);
          frame_bytes = frame_bytes + 5'd1;
        end else begin
          dropped = 1'b1;
        end
      end
      default: begin
        // check word with no data in the frame is ignored
        if (frame_bytes != 0) begin
          if (it.rx_crc == (frame_crc << 1)) begin
            link_good  = 1'b1;
            bad_checks = '0;
          end else begin
            link_good = 1'b0;
            if (bad_checks != c15cfe_pkg::MISMATCH_MAX) begin
              bad_checks = bad_checks + 8'd1;
            end
          end
          frame_crc   = c15cfe_pkg::CRC_SEED;
          frame_bytes = '0;
          owe_result(c15cfe_pkg::KIND_STATUS, 8'h00, 1'b1);
        end
      end
    endcase
  endtask

  // driver: offers the next queued word, random idle cycles as the phase asks
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid   <= 1'b0;
      frame_crc   = c15cfe_pkg::CRC_SEED;
      frame_bytes = '0;
      link_good   = 1'b0;
      bad_checks  = '0;
      dropped     = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_frame_words(req_on_bus);
      end
      // only move on once the offered word is gone, valid stays up across back-to-back words
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          req_on_bus = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, req_on_bus.rx_crc, req_on_bus.data_byte,
                        req_on_bus.command_code, req_on_bus.device_address};
          in_tuser  <= req_on_bus.req_type;
          in_tlast  <= req_on_bus.last_byte;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, every accepted result word checked against the oldest owed
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_tvalid && out_tready) begin
        seen.kind        = c15cfe_pkg::kind_t'(out_tuser);
        seen.tx_byte     = out_tdata[7:0];
        seen.end_of_run  = out_tlast;
        seen.crc_ok      = out_tdata[8];
        seen.error_total = out_tdata[16:9];
        seen.overflow    = out_tdata[17];
        if (owed_results.size() == 0) begin
          note_failure({"unexpected word ", fmt_result(seen)});
        end else begin
          want = owed_results.pop_front();
          if (seen !== want) begin
            note_failure({"expected ", fmt_result(want), " got ", fmt_result(seen)});
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_crc15_command_frame_engine: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // queue one request word and follow the frame crc on the stimulus side
  task automatic add_req(input c15cfe_pkg::req_t req, input logic [3:0] addr,
                         input logic [10:0] cmd, input logic [7:0] data, input logic last,
                         input logic [15:0] rx);
    c15cfe_pkg::item_t it;
    it.req_type       = req;
    it.device_address = addr;
    it.command_code   = cmd;
    it.data_byte      = data;
    it.last_byte      = last;
    it.rx_crc         = rx;
    pending_reqs.push_back(it);
    queued_items++;
    case (req)
      c15cfe_pkg::REQ_HEADER: begin
        gen_crc   = c15cfe_pkg::CRC_SEED;
        gen_bytes = '0;
      end
      c15cfe_pkg::REQ_TX_DATA, c15cfe_pkg::REQ_RX_DATA: begin
        if (gen_bytes < c15cfe_pkg::MAX_DATA) begin
          gen_crc   = crc15_feed(gen_crc, data);
          gen_bytes = gen_bytes + 5'd1;
        end
        if (req == c15cfe_pkg::REQ_TX_DATA && last && gen_bytes != 0) begin
          gen_crc   = c15cfe_pkg::CRC_SEED;
          gen_bytes = '0;
        end
      end
      default: begin
        if (gen_bytes != 0) begin
          gen_crc   = c15cfe_pkg::CRC_SEED;
          gen_bytes = '0;
        end
      end
    endcase
  endtask

  task automatic add_data(input c15cfe_pkg::req_t req, input logic [7:0] data,
                          input logic last);
    add_req(req, 4'($urandom), 11'($urandom), data, last, 16'($urandom));
  endtask

  // check word for the frame so far, optionally broken in a random nonzero pattern
  task automatic add_check(input logic broken);
    logic [15:0] word;
    word = gen_crc << 1;
    if (broken) begin
      word = word ^ 16'($urandom_range(1, 16'hffff));
    end
    add_req(c15cfe_pkg::REQ_RX_CRC, 4'($urandom), 11'($urandom), 8'($urandom),
            1'($urandom), word);
  endtask

  task automatic add_header();
    add_req(c15cfe_pkg::REQ_HEADER, 4'($urandom), 11'($urandom), 8'($urandom), 1'($urandom),
            16'($urandom));
  endtask

  task automatic gen_tx_frame(input int len);
    add_header();
    for (int i = 0; i < len; i++) begin
      // a stray last mark now and then splits the frame early
      add_data(c15cfe_pkg::REQ_TX_DATA, 8'($urandom),
               (i == len - 1) || ($urandom_range(19) == 0));
    end
  endtask

  task automatic gen_rx_frame(input int len, input logic broken);
    add_header();
    for (int i = 0; i < len; i++) begin
      add_data(c15cfe_pkg::REQ_RX_DATA, 8'($urandom), 1'($urandom));
    end
    add_check(broken);
  endtask

  // mostly well-formed frames, some of them past the byte limit, plus raw noise
  task automatic gen_traffic(input int n_items);
    int start;
    int pick;
    int len;
    start = queued_items;
    while (queued_items - start < n_items) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(24, 30) : $urandom_range(1, 8);
      if (pick < 40) begin
        gen_tx_frame(len);
      end else if (pick < 80) begin
        gen_rx_frame(len, $urandom_range(99) < 30);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          add_req(c15cfe_pkg::req_t'($urandom_range(3)), 4'($urandom), 11'($urandom),
                  8'($urandom), 1'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (pending_reqs.size() != 0 || in_tvalid || owed_results.size() != 0);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    sender_idle_pct    = send_pct;
    receiver_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed words, no idling
    set_idling(0, 0);
    add_req(c15cfe_pkg::REQ_HEADER, 4'd0, 11'd0, 8'h00, 1'b0, 16'h0000);
    add_req(c15cfe_pkg::REQ_HEADER, 4'hf, 11'h7ff, 8'hff, 1'b1, 16'hffff);
    add_data(c15cfe_pkg::REQ_TX_DATA, 8'h00, 1'b0);
    add_data(c15cfe_pkg::REQ_TX_DATA, 8'hff, 1'b1);
    // empty frame: check word with no data is ignored
    add_check(1'b0);
    add_req(c15cfe_pkg::REQ_HEADER, 4'h5, 11'h2aa, 8'h00, 1'b0, 16'h0000);
    // last mark on received bytes is ignored
    add_data(c15cfe_pkg::REQ_RX_DATA, 8'hff, 1'b1);
    add_data(c15cfe_pkg::REQ_RX_DATA, 8'h00, 1'b0);
    add_check(1'b0);
    add_data(c15cfe_pkg::REQ_RX_DATA, 8'ha5, 1'b0);
    add_req(c15cfe_pkg::REQ_RX_CRC, 4'h0, 11'h0, 8'h00, 1'b0, (gen_crc << 1) ^ 16'hffff);
    add_data(c15cfe_pkg::REQ_RX_DATA, 8'h5a, 1'b0);
    add_check(1'b0);
    // data with no header continues the running crc, sent and received bytes mixed
    add_data(c15cfe_pkg::REQ_TX_DATA, 8'h3c, 1'b1);
    add_data(c15cfe_pkg::REQ_RX_DATA, 8'h11, 1'b0);
    add_data(c15cfe_pkg::REQ_TX_DATA, 8'h22, 1'b1);
    add_req(c15cfe_pkg::REQ_HEADER, 4'ha, 11'h555, 8'h00, 1'b0, 16'h0000);
    add_data(c15cfe_pkg::REQ_RX_DATA, 8'h00, 1'b0);
    add_req(c15cfe_pkg::REQ_RX_CRC, 4'h0, 11'h0, 8'h00, 1'b0, 16'h0000);

    // run of failed checks climbs the mismatch counter, then a good check clears it
    add_header();
    repeat (30) begin
      add_data(c15cfe_pkg::REQ_RX_DATA, 8'($urandom), 1'($urandom));
      add_check(1'b1);
    end
    add_data(c15cfe_pkg::REQ_RX_DATA, 8'($urandom), 1'b0);
    add_check(1'b0);
    wait_drained();

    // sender idling; byte limit hit on both directions, incl. a dropped last byte
    set_idling(54, 0);
    gen_tx_frame(28);
    gen_rx_frame(27, 1'b1);
    gen_traffic(30);
    wait_drained();

    // receiver stalling
    set_idling(0, 54);
    gen_traffic(35);
    wait_drained();

    // both sides idling
    set_idling(22, 22);
    gen_traffic(35);
    wait_drained();

    // back to full rate
    set_idling(0, 0);
    gen_traffic(30);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("tb_crc15_command_frame_engine: clean");
    end else begin
      $display("tb_crc15_command_frame_engine: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/c15cfe_pkg.sv
rtl/c15cfe_framer.sv
rtl/crc15_command_frame_engine.sv
verif/tb_crc15_command_frame_engine.sv
